[rtl/trli_pkg.sv]
package trli_pkg;

    localparam int NUM_LEDS_DEF = 16;
    localparam int ANG_W        = 14;
    localparam int IN_W         = 48;   // three 14-bit angles, zero filled to bytes
    localparam int OUT_W        = 16;   // led index and green level, zero filled
    localparam int IDX_W        = 6;
    localparam int GRN_W        = 8;
    localparam int ANG_FULL     = 5760;
    localparam int ANG_QUARTER  = 1440;
    localparam int SINE_LAST    = 90;

    // round(16384 * sin(k deg)), k = 0..90
    localparam int SINE_Q14 [91] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRED,
        ST_STAB,
        ST_SMUL,
        ST_SFIN,
        ST_MOP,
        ST_MMUL,
        ST_MRND,
        ST_NORM,
        ST_LOP,
        ST_LMUL0,
        ST_LMUL1,
        ST_LACC,
        ST_LOUT
    } trli_state_t;

    // elaboration only: ring position sines
    function automatic logic signed [15:0] sine_const(input int a);
        int u;
        int q;
        int r;
        int k;
        int f;
        int mag;
        u = (a + 2 * ANG_FULL) % ANG_FULL;
        q = u / ANG_QUARTER;
        r = u % ANG_QUARTER;
        if ((q & 1) == 1)
        begin
            r = ANG_QUARTER - r;
        end
        k = r / 16;
        f = r % 16;
        if (k >= SINE_LAST)
        begin
            mag = SINE_Q14[SINE_LAST];
        end
        else
        begin
            mag = SINE_Q14[k] + (((SINE_Q14[k + 1] - SINE_Q14[k]) * f + 8) >> 4);
        end
        if (q >= 2)
        begin
            mag = -mag;
        end
        return 16'(mag);
    endfunction

endpackage

[rtl/tilt_ring_led_intensity_core.sv]
// channel | signals                         | word
// --------+---------------------------------+-----------------------------------------
// in      | s_tvalid s_tready s_tdata[47:0] | roll[13:0] yaw[27:14] pitch[41:28]
// out     | m_tvalid m_tready m_tdata[15:0] | led_index[5:0] green_level[13:6]
//         | m_tlast                         | last_led
//
// An unchanged reading is taken and gives no word.
// A changed reading computes six sines (reduce, table, multiply, finish) and
// seven products (operands, multiply, round), all on the one 16x16 multiplier,
// normalises, then for each LED forms two products, a sum and an output word.
// Output stalls hold the LED loop. Reset clears the sequencer, the stored angles and the output valid flag.
// s_tready is high only while the sequencer is idle.
module tilt_ring_led_intensity_core
    import trli_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // roll_angle, yaw_angle, pitch_angle, zeros
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // led_index, green_level, zeros
    output logic             m_tlast
);

    localparam int LED_W = $clog2(NUM_LEDS);

    trli_state_t state_reg, state_next;

    logic [ANG_W-1:0] prev_roll_reg, prev_yaw_reg, prev_pitch_reg;
    logic [2:0]       sidx_reg;
    logic [2:0]       midx_reg;
    logic [LED_W-1:0] led_reg;

    logic [10:0]        r_reg;
    logic               neg_reg;
    logic signed [15:0] base_reg;
    logic signed [15:0] op_a_reg, op_b_reg;
    logic signed [31:0] prod_reg;
    logic signed [15:0] sr_reg, cr_reg, sy_reg, cy_reg, sp_reg, cp_reg;
    logic signed [15:0] t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic signed [15:0] n0_reg, n1_reg, n2_reg;
    logic signed [33:0] acc_reg;

    logic             out_valid_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic [GRN_W-1:0] out_grn_reg;
    logic             out_last_reg;

    logic             changed;
    logic             out_free;
    logic             out_load;
    logic             led_last;

    logic signed [15:0] led_px [NUM_LEDS];
    logic signed [15:0] led_py [NUM_LEDS];

    genvar g;
    generate
        for (g = 0; g < NUM_LEDS; g++)
        begin : g_led
            localparam int ANG = (ANG_FULL * g + NUM_LEDS / 2) / NUM_LEDS;
            assign led_px[g] = sine_const(ANG);
            assign led_py[g] = sine_const(ANG + ANG_QUARTER);
        end
    endgenerate

    assign changed  = (s_tdata[13:0] != prev_roll_reg) || (s_tdata[27:14] != prev_yaw_reg)
                   || (s_tdata[41:28] != prev_pitch_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign led_last = (led_reg == LED_W'(NUM_LEDS - 1));

    // sine argument reduction
    logic [ANG_W-1:0]   ang_sel;
    logic signed [15:0] ang_ext;
    logic [15:0]        ang_off;
    logic [15:0]        ang_u;
    logic [15:0]        ang_r;
    logic [1:0]         quad;
    logic [10:0]        r_next;

    always_comb
    begin
        case (sidx_reg[2:1])
            2'd0:    ang_sel = prev_roll_reg;
            2'd1:    ang_sel = prev_yaw_reg;
            default: ang_sel = prev_pitch_reg;
        endcase
        ang_ext = {{2{ang_sel[ANG_W-1]}}, ang_sel} + (sidx_reg[0] ? 16'sd1440 : 16'sd0);
        ang_off = 16'(ang_ext + 16'sd11520);
        if (ang_off >= 16'd17280)
        begin
            ang_u = ang_off - 16'd17280;
        end
        else if (ang_off >= 16'd11520)
        begin
            ang_u = ang_off - 16'd11520;
        end
        else if (ang_off >= 16'd5760)
        begin
            ang_u = ang_off - 16'd5760;
        end
        else
        begin
            ang_u = ang_off;
        end
        if (ang_u >= 16'd4320)
        begin
            quad  = 2'd3;
            ang_r = ang_u - 16'd4320;
        end
        else if (ang_u >= 16'd2880)
        begin
            quad  = 2'd2;
            ang_r = ang_u - 16'd2880;
        end
        else if (ang_u >= 16'd1440)
        begin
            quad  = 2'd1;
            ang_r = ang_u - 16'd1440;
        end
        else
        begin
            quad  = 2'd0;
            ang_r = ang_u;
        end
        if (quad[0])
        begin
            r_next = 11'(16'd1440 - ang_r);
        end
        else
        begin
            r_next = ang_r[10:0];
        end
    end

    // table lookup for interpolation
    logic [6:0]  tk_idx, tk1_idx;
    logic [14:0] tk, tk1;

    always_comb
    begin
        tk_idx  = r_reg[10:4];
        tk1_idx = (tk_idx >= 7'(SINE_LAST)) ? tk_idx : tk_idx + 7'd1;
        tk      = 15'(SINE_Q14[tk_idx]);
        tk1     = 15'(SINE_Q14[tk1_idx]);
    end

    logic signed [15:0] mag, sine_val;
    logic signed [32:0] rnd_sum;
    logic signed [15:0] rnd_val;

    always_comb
    begin
        mag      = base_reg + 16'((prod_reg + 32'sd8) >>> 4);
        sine_val = neg_reg ? -mag : mag;
        rnd_sum  = ({prod_reg[31], prod_reg} + 33'sd8192) >>> 14;
        rnd_val  = rnd_sum[15:0];
    end

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        if (v > 17'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (v < -17'sd32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    logic signed [16:0] sum0, sum1;

    assign sum0 = -{t1_reg[15], t1_reg} - {t2_reg[15], t2_reg};
    assign sum1 = -{t3_reg[15], t3_reg} + {t4_reg[15], t4_reg};

    // intensity from dot product
    logic signed [33:0] dx;
    logic signed [42:0] num;
    logic [GRN_W-1:0]   green;

    always_comb
    begin
        dx  = 34'sd268435456 - acc_reg;
        num = {dx[33], dx, 8'd0} - {{9{dx[33]}}, dx};
        if (num[42] || (num == 43'sd0))
        begin
            green = '0;
        end
        else if (num[41:36] != 6'd0)
        begin
            green = 8'hFF;
        end
        else
        begin
            green = num[35:28];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && changed)
                begin
                    state_next = ST_SRED;
                end
            end
            ST_SRED:  state_next = ST_STAB;
            ST_STAB:  state_next = ST_SMUL;
            ST_SMUL:  state_next = ST_SFIN;
            ST_SFIN:  state_next = (sidx_reg == 3'd5) ? ST_MOP : ST_SRED;
            ST_MOP:   state_next = ST_MMUL;
            ST_MMUL:  state_next = ST_MRND;
            ST_MRND:  state_next = (midx_reg == 3'd6) ? ST_NORM : ST_MOP;
            ST_NORM:  state_next = ST_LOP;
            ST_LOP:   state_next = ST_LMUL0;
            ST_LMUL0: state_next = ST_LMUL1;
            ST_LMUL1: state_next = ST_LACC;
            ST_LACC:  state_next = ST_LOUT;
            ST_LOUT:
            begin
                if (out_free)
                begin
                    state_next = led_last ? ST_IDLE : ST_LOP;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        out_load = (state_reg == ST_LOUT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_roll_reg  <= '0;
            prev_yaw_reg   <= '0;
            prev_pitch_reg <= '0;
            sidx_reg       <= '0;
            midx_reg       <= '0;
            led_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_tready && s_tvalid && changed)
            begin
                prev_roll_reg  <= s_tdata[13:0];
                prev_yaw_reg   <= s_tdata[27:14];
                prev_pitch_reg <= s_tdata[41:28];
                sidx_reg       <= '0;
            end
            if (state_reg == ST_SFIN)
            begin
                sidx_reg <= sidx_reg + 3'd1;
                midx_reg <= '0;
            end
            if (state_reg == ST_MRND)
            begin
                midx_reg <= midx_reg + 3'd1;
            end
            if (state_reg == ST_NORM)
            begin
                led_reg <= '0;
            end
            if (out_load && !led_last)
            begin
                led_reg <= led_reg + LED_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // shared multiplier, free running
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a_reg * op_b_reg;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_SRED:
            begin
                r_reg   <= r_next;
                neg_reg <= quad[1];
            end
            ST_STAB:
            begin
                base_reg <= {1'b0, tk};
                op_a_reg <= {1'b0, tk1} - {1'b0, tk};
                op_b_reg <= {12'd0, r_reg[3:0]};
            end
            ST_SFIN:
            begin
                case (sidx_reg)
                    3'd0:    sr_reg <= sine_val;
                    3'd1:    cr_reg <= sine_val;
                    3'd2:    sy_reg <= sine_val;
                    3'd3:    cy_reg <= sine_val;
                    3'd4:    sp_reg <= sine_val;
                    default: cp_reg <= sine_val;
                endcase
            end
            ST_MOP:
            begin
                case (midx_reg)
                    3'd0:
                    begin
                        op_a_reg <= sy_reg;
                        op_b_reg <= sp_reg;
                    end
                    3'd1:
                    begin
                        op_a_reg <= t1_reg;
                        op_b_reg <= cr_reg;
                    end
                    3'd2:
                    begin
                        op_a_reg <= cy_reg;
                        op_b_reg <= sr_reg;
                    end
                    3'd3:
                    begin
                        op_a_reg <= cy_reg;
                        op_b_reg <= sp_reg;
                    end
                    3'd4:
                    begin
                        op_a_reg <= t3_reg;
                        op_b_reg <= cr_reg;
                    end
                    3'd5:
                    begin
                        op_a_reg <= sy_reg;
                        op_b_reg <= sr_reg;
                    end
                    default:
                    begin
                        op_a_reg <= cp_reg;
                        op_b_reg <= cr_reg;
                    end
                endcase
            end
            ST_MRND:
            begin
                case (midx_reg)
                    3'd0, 3'd1: t1_reg <= rnd_val;
                    3'd2:       t2_reg <= rnd_val;
                    3'd3, 3'd4: t3_reg <= rnd_val;
                    3'd5:       t4_reg <= rnd_val;
                    default:    t5_reg <= rnd_val;
                endcase
            end
            ST_NORM:
            begin
                n0_reg <= sat16(sum0);
                n1_reg <= sat16(sum1);
                n2_reg <= t5_reg;
            end
            ST_LOP:
            begin
                op_a_reg <= n0_reg;
                op_b_reg <= led_px[led_reg];
            end
            ST_LMUL0:
            begin
                op_a_reg <= n1_reg;
                op_b_reg <= led_py[led_reg];
            end
            ST_LMUL1:
            begin
                // z term of each ring point is one half
                acc_reg <= {{5{n2_reg[15]}}, n2_reg, 13'd0} + {{2{prod_reg[31]}}, prod_reg};
            end
            ST_LACC:
            begin
                acc_reg <= acc_reg + {{2{prod_reg[31]}}, prod_reg};
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_idx_reg  <= IDX_W'(led_reg);
            out_grn_reg  <= green;
            out_last_reg <= led_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_grn_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

[rtl/trli_chk.sv]
module trli_chk
    import trli_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tlast
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // no reading taken while an update still has LEDs to come
    a_busy_shown: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of an update");

    // the final LED may load as the one before it leaves
    a_busy_taken: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !s_tready || (m_tvalid && m_tlast))
        else $error("input ready before the final LED");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[5:0] == 6'(NUM_LEDS - 1))))
        else $error("tlast does not match the final ring position");

endmodule

bind tilt_ring_led_intensity_core trli_chk #(.NUM_LEDS(NUM_LEDS)) u_trli_chk (.*);

[bench/tilt_ring_led_checker.sv]
`timescale 1ns / 1ps
module tilt_ring_led_checker
    import trli_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    input  logic             m_tlast,
    output int               mismatch_count,
    output int               leds_pending
);

    localparam int Q14_ONE  = 16384;
    localparam int Q14_HALF = 8192;

    // round(16384 * sin(k deg)), k = 0..90
    localparam int QUARTER_WAVE [91] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    typedef struct packed {
        logic [IDX_W-1:0] led_index;
        logic [GRN_W-1:0] green_level;
        logic             last_led;
    } led_word_t;

    led_word_t           expected_leds [$];
    logic [ANG_W-1:0]    held_roll;
    logic [ANG_W-1:0]    held_yaw;
    logic [ANG_W-1:0]    held_pitch;

    // sine in Q1.14 of an angle in 1/16 degree, linear between whole degrees
    function automatic int sine_sixteenths(input int a);
        int wrapped;
        int quadrant;
        int offset;
        int whole;
        int frac;
        int magnitude;
        wrapped  = (a + 2 * ANG_FULL) % ANG_FULL;
        quadrant = wrapped / ANG_QUARTER;
        offset   = wrapped % ANG_QUARTER;
        if (quadrant % 2 == 1)
        begin
            offset = ANG_QUARTER - offset;
        end
        whole = offset / 16;
        frac  = offset % 16;
        if (whole >= 90)
        begin
            magnitude = QUARTER_WAVE[90];
        end
        else
        begin
            magnitude = QUARTER_WAVE[whole]
                      + (((QUARTER_WAVE[whole + 1] - QUARTER_WAVE[whole]) * frac + 8) >>> 4);
        end
        return (quadrant >= 2) ? -magnitude : magnitude;
    endfunction

    // Q14 product, round half up
    function automatic int q14_mul(input int a, input int b);
        longint p;
        p = longint'(a) * longint'(b) + Q14_HALF;
        return int'(p >>> 14);
    endfunction

    function automatic int clamp_q2_14(input int v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    task automatic predict_ring_levels(input logic [ANG_W-1:0] roll_raw,
                                       input logic [ANG_W-1:0] yaw_raw,
                                       input logic [ANG_W-1:0] pitch_raw);
        int        roll;
        int        yaw;
        int        pitch;
        int        s_roll;
        int        c_roll;
        int        s_yaw;
        int        c_yaw;
        int        s_pitch;
        int        c_pitch;
        int        tilt_x;
        int        tilt_y;
        int        tilt_z;
        int        led_ang;
        int        px;
        int        py;
        longint    dot;
        longint    scaled;
        longint    green;
        led_word_t w;
        if (roll_raw == held_roll && yaw_raw == held_yaw && pitch_raw == held_pitch)
        begin
            return;
        end
        held_roll  = roll_raw;
        held_yaw   = yaw_raw;
        held_pitch = pitch_raw;

        roll    = $signed(roll_raw);
        yaw     = $signed(yaw_raw);
        pitch   = $signed(pitch_raw);
        s_roll  = sine_sixteenths(roll);
        c_roll  = sine_sixteenths(roll + ANG_QUARTER);
        s_yaw   = sine_sixteenths(yaw);
        c_yaw   = sine_sixteenths(yaw + ANG_QUARTER);
        s_pitch = sine_sixteenths(pitch);
        c_pitch = sine_sixteenths(pitch + ANG_QUARTER);

        tilt_x = clamp_q2_14(-q14_mul(q14_mul(s_yaw, s_pitch), c_roll) - q14_mul(c_yaw, s_roll));
        tilt_y = clamp_q2_14(-q14_mul(q14_mul(c_yaw, s_pitch), c_roll) + q14_mul(s_yaw, s_roll));
        tilt_z = clamp_q2_14(q14_mul(c_pitch, c_roll));

        for (int i = 0; i < NUM_LEDS; i++)
        begin
            led_ang = (ANG_FULL * i + NUM_LEDS / 2) / NUM_LEDS;
            px      = sine_sixteenths(led_ang);
            py      = sine_sixteenths(led_ang + ANG_QUARTER);
            dot     = longint'(tilt_x) * px + longint'(tilt_y) * py
                    + longint'(tilt_z) * Q14_HALF;
            scaled  = ((longint'(1) <<< 28) - dot) * 255;
            if (scaled <= 0)
            begin
                green = 0;
            end
            else
            begin
                green = scaled >>> 28;
                if (green > 255)
                begin
                    green = 255;
                end
            end
            w.led_index   = IDX_W'(i);
            w.green_level = GRN_W'(green);
            w.last_led    = (i == NUM_LEDS - 1);
            expected_leds.push_back(w);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        led_word_t got;
        led_word_t want;
        if (!rst_n)
        begin
            held_roll      = '0;
            held_yaw       = '0;
            held_pitch     = '0;
            expected_leds.delete();
            mismatch_count <= 0;
            leds_pending   <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.led_index   = m_tdata[IDX_W-1:0];
                got.green_level = m_tdata[IDX_W+GRN_W-1:IDX_W];
                got.last_led    = m_tlast;
                if (expected_leds.size() == 0)
                begin
                    $display("%0t: unexpected LED word: index %0d green %0d last %0b",
                             $time, got.led_index, got.green_level, got.last_led);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_leds.pop_front();
                    if (got.led_index !== want.led_index
                        || got.green_level !== want.green_level
                        || got.last_led !== want.last_led)
                    begin
                        $display("%0t: LED word mismatch: expected index %0d green %0d last %0b, got index %0d green %0d last %0b",
                                 $time, want.led_index, want.green_level, want.last_led,
                                 got.led_index, got.green_level, got.last_led);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_ring_levels(s_tdata[ANG_W-1:0], s_tdata[2*ANG_W-1:ANG_W],
                                    s_tdata[3*ANG_W-1:2*ANG_W]);
            end
            leds_pending <= expected_leds.size();
        end
    end

endmodule

[bench/tilt_ring_led_intensity_core_tb.sv]
`timescale 1ns / 1ps
module tilt_ring_led_intensity_core_tb;
    import trli_pkg::*;

    localparam int READINGS     = 320;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;
    localparam int N_DIRECTED   = 24;

    // roll, yaw, pitch in 1/16 degree
    localparam int DIRECTED [N_DIRECTED][3] = '{
        '{0, 0, 0},             // same as reset value: no word
        '{0, 0, 0},
        '{1, 0, 0},             // one angle differs
        '{1, 0, 0},
        '{1, 1, 0},
        '{1, 1, 1},
        '{5760, 5760, 5760},
        '{-5760, -5760, -5760},
        '{8191, 8191, 8191},    // beyond a full turn
        '{-8192, -8192, -8192},
        '{-1, -1, -1},
        '{5461, -5462, 5461},
        '{-5462, 5461, -5462},
        '{1440, 0, 0},
        '{2880, 0, 0},          // flipped normal: green saturates high
        '{4320, 0, 0},
        '{-1440, 0, 0},         // normal on an LED: green down to zero
        '{-1440, 1440, 0},
        '{0, 1440, 0},
        '{0, 0, 1440},
        '{0, 2880, 2880},
        '{15, -15, 16},
        '{1439, 1441, -1439},
        '{0, 0, 0}
    };

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;

    int               mismatch_count;
    int               leds_pending;
    int               idle_cycles;
    logic [ANG_W-1:0] sent_roll;
    logic [ANG_W-1:0] sent_yaw;
    logic [ANG_W-1:0] sent_pitch;
    bit               sender_quiet;
    bit               receiver_quiet;

    tilt_ring_led_intensity_core #(
        .NUM_LEDS (NUM_LEDS_DEF)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    tilt_ring_led_checker #(
        .NUM_LEDS (NUM_LEDS_DEF)
    ) led_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .leds_pending   (leds_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // mostly in range, some raw 14-bit values, some near quadrant edges
    function automatic logic [ANG_W-1:0] pick_angle();
        case ($urandom_range(0, 9))
            0, 1:
            begin
                return ANG_W'($urandom);
            end
            2:
            begin
                return ANG_W'(ANG_QUARTER * int'($urandom_range(0, 8)) - ANG_FULL
                              + int'($urandom_range(0, 4)) - 2);
            end
            default:
            begin
                return ANG_W'(int'($urandom_range(0, 2 * ANG_FULL)) - ANG_FULL);
            end
        endcase
    endfunction

    task automatic send_reading(input logic [ANG_W-1:0] roll,
                                input logic [ANG_W-1:0] yaw,
                                input logic [ANG_W-1:0] pitch);
        int gap;
        if ($urandom_range(0, 31) == 0)
        begin
            sender_quiet = !sender_quiet;
        end
        gap = sender_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - 3 * ANG_W){1'b0}}, pitch, yaw, roll};
        do
            @(posedge clk);
        while (!s_tready);
        sent_roll  = roll;
        sent_yaw   = yaw;
        sent_pitch = pitch;
    endtask

    // output side back-pressure
    initial
    begin
        int stall;
        m_tready       = 1'b0;
        receiver_quiet = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                receiver_quiet = !receiver_quiet;
            end
            stall = receiver_quiet ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    initial
    begin
        logic [ANG_W-1:0] roll;
        logic [ANG_W-1:0] yaw;
        logic [ANG_W-1:0] pitch;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        idle_cycles  = 0;
        sent_roll    = '0;
        sent_yaw     = '0;
        sent_pitch   = '0;
        sender_quiet = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_reading(ANG_W'(DIRECTED[i][0]), ANG_W'(DIRECTED[i][1]),
                         ANG_W'(DIRECTED[i][2]));
        end

        for (int n = N_DIRECTED; n < READINGS; n++)
        begin
            roll  = sent_roll;
            yaw   = sent_yaw;
            pitch = sent_pitch;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    roll  = pick_angle();
                    yaw   = pick_angle();
                    pitch = pick_angle();
                end
                5, 6, 7, 8:
                begin
                    case ($urandom_range(0, 2))
                        0: roll  = pick_angle();
                        1: yaw   = pick_angle();
                        default: pitch = pick_angle();
                    endcase
                end
                default:
                begin
                    // resend the held reading unchanged
                end
            endcase
            send_reading(roll, yaw, pitch);
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (leds_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && leds_pending == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
